// ----- rtl/nfc_host_frame_codec_top_macros.svh -----
// assertion helpers shared by the codec rtl
`ifndef NFC_HOST_FRAME_CODEC_TOP_MACROS_SVH
`define NFC_HOST_FRAME_CODEC_TOP_MACROS_SVH

// antecedent implies consequent in the same cycle
`define NFCH_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// condition must never hold
`define NFCH_ASSERT_NEVER(lbl, cond, msg) \
  `NFCH_ASSERT_IMP(lbl, 1'b1, !(cond), msg)

`endif

// ----- rtl/nfch_pkg.sv -----
`timescale 1ns / 1ps

package nfch_pkg;

  // frame size limit default
  localparam int MaxFrameBytesDef = 200;

  // job queue depth between classifier and emitter
  localparam int QueueDepth = 4;

  // register reset
  localparam logic [7:0] MaxRespLenReset = 8'd192;

  // frame constants
  localparam logic [7:0] TfiHost = 8'hd4;
  localparam logic [7:0] TfiChip = 8'hd5;

  typedef enum logic [1:0] {
    MODE_TX      = 2'd0,
    MODE_RX_ACK  = 2'd1,
    MODE_RX_DATA = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    KIND_TX_BYTE = 2'd0,
    KIND_RX_BYTE = 2'd1,
    KIND_STATUS  = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NOT_READY = 3'd1,
    ST_FRAMING   = 3'd2,
    ST_NACKED    = 3'd3,
    ST_TOO_LONG  = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    OP_TX     = 2'd0,
    OP_RX     = 2'd1,
    OP_STATUS = 2'd2
  } job_op_e;

  // output sequence positions of one job
  localparam logic [3:0] PosPre   = 4'd0;
  localparam logic [3:0] PosSc0   = 4'd1;
  localparam logic [3:0] PosSc1   = 4'd2;
  localparam logic [3:0] PosLen   = 4'd3;
  localparam logic [3:0] PosLcs   = 4'd4;
  localparam logic [3:0] PosTfi   = 4'd5;
  localparam logic [3:0] PosData  = 4'd6;
  localparam logic [3:0] PosTrail = 4'd7;
  localparam logic [3:0] PosPost  = 4'd8;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] in_byte;
    logic       first_byte;
    logic       last_byte;
    logic [7:0] payload_len;
  } in_item_t;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] out_byte;
    status_e    status;
    logic       end_of_run;
  } out_item_t;

  // one classified item, expanded by the emitter
  typedef struct packed {
    job_op_e    op;
    logic [3:0] start;
    logic [3:0] last_pos;
    logic [7:0] len;
    logic [7:0] data;
    logic [7:0] dcs;
    status_e    status;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

endpackage

// ----- rtl/nfch_if.sv -----
`timescale 1ns / 1ps

// input item channel
interface nfch_in_if import nfch_pkg::*;;
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// result item channel
interface nfch_out_if import nfch_pkg::*;;
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/nfch_front.sv -----
`timescale 1ns / 1ps

module nfch_front import nfch_pkg::*; #(
  parameter int MAX_FRAME_BYTES = MaxFrameBytesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_data_i,
  nfch_in_if.sink     in_i,
  input  queue_stat_t q_stat_i,
  output logic        push_o,
  output job_t        job_o
);

  // receive byte positions within one chip read
  localparam logic [7:0] RxSc0  = 8'd1;
  localparam logic [7:0] RxSc1  = 8'd2;
  localparam logic [7:0] RxSc2  = 8'd3;
  localparam logic [7:0] RxLen  = 8'd4;
  localparam logic [7:0] RxLcs  = 8'd5;
  localparam logic [7:0] RxTfi  = 8'd6;
  localparam logic [7:0] RxCode = 8'd7;

  logic [7:0] max_len_q;
  logic [7:0] chk_q, chk_d;
  logic       abort_q, abort_d;
  logic [7:0] pos_q, pos_d;
  logic [7:0] left_q, left_d;
  logic       nack_q, nack_d;
  logic       fin_q, fin_d;
  logic       job_vld;
  logic       accept;
  logic [7:0] sum;
  logic [7:0] left_new;
  in_item_t   it;

  function automatic job_t status_job(status_e st, logic [7:0] b);
    job_t j;
    j.op       = OP_STATUS;
    j.start    = PosTrail;
    j.last_pos = PosTrail;
    j.len      = 8'd0;
    j.data     = b;
    j.dcs      = 8'd0;
    j.status   = st;
    return j;
  endfunction

  assign it       = in_i.data;
  assign in_i.ready = !q_stat_i.full;
  assign accept   = in_i.valid && in_i.ready;
  assign push_o   = accept && job_vld;

  // classify one item and work out the next link state
  always_comb begin
    chk_d    = chk_q;
    abort_d  = abort_q;
    pos_d    = pos_q;
    left_d   = left_q;
    nack_d   = nack_q;
    fin_d    = fin_q;
    job_vld  = 1'b0;
    job_o    = status_job(ST_OK, it.in_byte);
    sum      = 8'd0;
    left_new = left_q - {7'd0, left_q != 8'd0};
    case (it.mode)
      MODE_TX: begin
        if (it.first_byte) begin
          if (int'(it.payload_len) + 8 > MAX_FRAME_BYTES) begin
            abort_d = 1'b1;
            job_vld = 1'b1;
            job_o   = status_job(ST_TOO_LONG, it.in_byte);
          end else begin
            abort_d        = 1'b0;
            sum            = TfiHost + it.in_byte;
            chk_d          = sum;
            job_vld        = 1'b1;
            job_o.op       = OP_TX;
            job_o.start    = PosPre;
            job_o.last_pos = it.last_byte ? PosPost : PosData;
            job_o.len      = it.payload_len + 8'd1;
            job_o.dcs      = 8'd0 - sum;
          end
        end else if (!abort_q) begin
          sum            = chk_q + it.in_byte;
          chk_d          = sum;
          job_vld        = 1'b1;
          job_o.op       = OP_TX;
          job_o.start    = PosData;
          job_o.last_pos = it.last_byte ? PosPost : PosData;
          job_o.dcs      = 8'd0 - sum;
        end
      end
      MODE_RX_ACK, MODE_RX_DATA: begin
        if (it.first_byte) begin
          pos_d  = 8'd0;
          nack_d = 1'b0;
          left_d = 8'd0;
          if (!it.in_byte[0]) begin
            fin_d   = 1'b1;
            job_vld = 1'b1;
            job_o   = status_job(ST_NOT_READY, it.in_byte);
          end else begin
            fin_d = 1'b0;
            pos_d = RxSc0;
          end
        end else if (!fin_q) begin
          if (pos_q != 8'hff) begin
            pos_d = pos_q + 8'd1;
          end
          case (pos_q)
            RxSc0, RxSc1: begin
              if (it.in_byte != 8'h00) begin
                fin_d   = 1'b1;
                job_vld = 1'b1;
                job_o   = status_job(ST_FRAMING, it.in_byte);
              end
            end
            RxSc2: begin
              if (it.in_byte != 8'hff) begin
                fin_d   = 1'b1;
                job_vld = 1'b1;
                job_o   = status_job(ST_FRAMING, it.in_byte);
              end
            end
            default: begin
              if (it.mode == MODE_RX_ACK) begin
                // ack frame: code bytes, then postamble
                case (pos_q)
                  RxLen: nack_d = nack_q | (it.in_byte != 8'h00);
                  RxLcs: nack_d = nack_q | (it.in_byte != 8'hff);
                  default: begin
                    fin_d   = 1'b1;
                    job_vld = 1'b1;
                    if (it.in_byte != 8'h00) begin
                      job_o = status_job(ST_FRAMING, it.in_byte);
                    end else begin
                      job_o = status_job(nack_q ? ST_NACKED : ST_OK, it.in_byte);
                    end
                  end
                endcase
              end else begin
                // data frame: length, tfi, then payload
                case (pos_q)
                  RxLen: begin
                    nack_d = it.in_byte < 8'd2;
                    left_d = it.in_byte - 8'd2;
                  end
                  RxLcs, RxCode: begin
                  end
                  RxTfi: begin
                    if (it.in_byte != TfiChip) begin
                      fin_d   = 1'b1;
                      job_vld = 1'b1;
                      job_o   = status_job(ST_FRAMING, it.in_byte);
                    end else if (nack_q || left_q > max_len_q ||
                                 int'(left_q) + 8 > MAX_FRAME_BYTES) begin
                      fin_d   = 1'b1;
                      job_vld = 1'b1;
                      job_o   = status_job(ST_TOO_LONG, it.in_byte);
                    end else if (left_q == 8'd0) begin
                      fin_d   = 1'b1;
                      job_vld = 1'b1;
                      job_o   = status_job(ST_OK, it.in_byte);
                    end
                  end
                  default: begin
                    left_d         = left_new;
                    job_vld        = 1'b1;
                    job_o.op       = OP_RX;
                    job_o.start    = PosData;
                    job_o.last_pos = (left_new == 8'd0) ? PosTrail : PosData;
                    job_o.status   = ST_OK;
                    if (left_new == 8'd0) begin
                      fin_d = 1'b1;
                    end
                  end
                endcase
              end
            end
          endcase
        end
      end
      default: begin
      end
    endcase
  end

  // link state, updated on each input transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chk_q   <= 8'd0;
      abort_q <= 1'b0;
      pos_q   <= 8'd0;
      left_q  <= 8'd0;
      nack_q  <= 1'b0;
      fin_q   <= 1'b1;
    end else if (accept) begin
      chk_q   <= chk_d;
      abort_q <= abort_d;
      pos_q   <= pos_d;
      left_q  <= left_d;
      nack_q  <= nack_d;
      fin_q   <= fin_d;
    end
  end

  // response length limit register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= MaxRespLenReset;
    end else if (cfg_we_i) begin
      max_len_q <= cfg_data_i;
    end
  end

endmodule

// ----- rtl/nfch_queue.sv -----
`timescale 1ns / 1ps

module nfch_queue import nfch_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  job_t        job_i,
  input  logic        pop_i,
  output job_t        head_o,
  output queue_stat_t stat_o
);

  localparam int PtrW = $clog2(QueueDepth);
  localparam int CntW = $clog2(QueueDepth + 1);

  job_t            mem_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q;
  logic [PtrW-1:0] rd_ptr_q;
  logic [CntW-1:0] cnt_q;

  assign stat_o.full  = cnt_q == CntW'(QueueDepth);
  assign stat_o.empty = cnt_q == '0;
  assign head_o       = mem_q[rd_ptr_q];

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

// ----- rtl/nfch_back.sv -----
`timescale 1ns / 1ps

module nfch_back import nfch_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  job_t        head_i,
  input  queue_stat_t q_stat_i,
  output logic        pop_o,
  nfch_out_if.source  out_o
);

  logic       in_job_q;
  logic [3:0] step_q;
  logic       out_valid_q;
  out_item_t  out_data_q;
  out_item_t  res;
  logic [3:0] pos;
  logic       emit;
  logic       at_end;

  assign pos    = in_job_q ? step_q : head_i.start;
  assign emit   = !q_stat_i.empty && (!out_valid_q || out_o.ready);
  assign at_end = pos == head_i.last_pos;
  assign pop_o  = emit && at_end;

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

  // result item at the current position of the head job
  always_comb begin
    res.kind       = KIND_TX_BYTE;
    res.out_byte   = 8'h00;
    res.status     = ST_OK;
    res.end_of_run = at_end;
    case (pos)
      PosPre, PosSc0, PosPost: res.out_byte = 8'h00;
      PosSc1:  res.out_byte = 8'hff;
      PosLen:  res.out_byte = head_i.len;
      PosLcs:  res.out_byte = 8'd0 - head_i.len;
      PosTfi:  res.out_byte = TfiHost;
      PosData: begin
        res.kind     = (head_i.op == OP_RX) ? KIND_RX_BYTE : KIND_TX_BYTE;
        res.out_byte = head_i.data;
      end
      PosTrail: begin
        if (head_i.op == OP_TX) begin
          res.out_byte = head_i.dcs;
        end else begin
          res.kind   = KIND_STATUS;
          res.status = head_i.status;
        end
      end
      default: res.out_byte = 8'h00;
    endcase
  end

  // job walk and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_job_q    <= 1'b0;
      step_q      <= 4'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (emit) begin
        in_job_q <= !at_end;
        step_q   <= pos + 4'd1;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // output payload register
  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_data_q <= res;
    end
  end

endmodule

// ----- rtl/nfc_host_frame_codec_top.sv -----
`timescale 1ns / 1ps
// Host-side framer and deframer for a length/checksum information frame link.
// Mode 0 wraps payload bytes into frames, modes 1 and 2 check the bytes of a
// chip read and pass out data-frame payload. The input side takes one byte per
// cycle; each byte turns into zero to nine results, which leave one per cycle
// while out_o is ready, through a registered output, so a first transmit byte
// (header, data, and for a one-byte frame checksum and postamble) yields up to
// nine results. A four-entry job queue sits between the classifier and the
// result emitter, so input stalls only while four jobs, the one being expanded
// included, sit in the queue; the sustained rate is one result per cycle at
// the output port. max_response_len is written via cfg_we_i/cfg_data_i by the
// user only while the block is idle, unenforced. No clearing pass after reset.
`include "nfc_host_frame_codec_top_macros.svh"

module nfc_host_frame_codec_top import nfch_pkg::*; #(
  parameter int MAX_FRAME_BYTES = MaxFrameBytesDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_data_i,
  nfch_in_if.sink    in_i,
  nfch_out_if.source out_o
);

  queue_stat_t q_stat;
  logic        push;
  logic        pop;
  job_t        push_job;
  job_t        head_job;
  logic        res_is_status;
  logic        res_is_byte;
  logic        res_closed;
  logic        res_status_ok;

  // classifier and link state
  nfch_front #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_i),
    .q_stat_i   (q_stat),
    .push_o     (push),
    .job_o      (push_job)
  );

  // job queue
  nfch_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .job_i  (push_job),
    .pop_i  (pop),
    .head_o (head_job),
    .stat_o (q_stat)
  );

  // result emitter
  nfch_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .head_i   (head_job),
    .q_stat_i (q_stat),
    .pop_o    (pop),
    .out_o    (out_o)
  );

  // result classification for the checks
  assign res_is_status = out_o.valid && out_o.data.kind == KIND_STATUS;
  assign res_is_byte   = out_o.valid && out_o.data.kind != KIND_STATUS;
  assign res_closed    = out_o.data.end_of_run && out_o.data.out_byte == 8'h00;
  assign res_status_ok = out_o.data.status == ST_OK;

  // checks
  `NFCH_ASSERT_IMP(a_status_ends_run, res_is_status, res_closed, "open or nonzero status result")
  `NFCH_ASSERT_IMP(a_byte_ok_status, res_is_byte, res_status_ok, "byte result with a status")
  `NFCH_ASSERT_NEVER(a_pop_empty, pop && q_stat.empty, "job popped from an empty queue")
  `NFCH_ASSERT_NEVER(a_queue_count, q_stat.full && q_stat.empty, "queue full and empty at once")

endmodule
